// ===== rtl/pnp_pkg.sv =====
package pnp_pkg;

	localparam int RUNS = 4;
	localparam int R_BIN = 0;
	localparam int R_OCT = 1;
	localparam int R_DEC = 2;
	localparam int R_HEX = 3;

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_LB    = 8'h62;
	localparam logic [7:0] CH_UB    = 8'h42;

	localparam logic [4:0] DIGIT_NONE  = 5'd16;
	localparam logic [4:0] DIGIT_SEVEN = 5'd7;
	localparam logic [4:0] DIGIT_TEN   = 5'd10;

	localparam logic [2:0] FORM_DEC    = 3'd0;
	localparam logic [2:0] FORM_OCT    = 3'd1;
	localparam logic [2:0] FORM_HEX_LX = 3'd2;
	localparam logic [2:0] FORM_HEX_UX = 3'd3;
	localparam logic [2:0] FORM_BIN_LB = 3'd4;
	localparam logic [2:0] FORM_BIN_UB = 3'd5;

	localparam int AF_BIN = 0;
	localparam int AF_OCT = 1;
	localparam int AF_HEX = 2;
	localparam logic [3:0] AF_ONLY_BIN = 4'd9;
	localparam logic [3:0] AF_ONLY_OCT = 4'd10;
	localparam logic [3:0] AF_ONLY_HEX = 4'd12;

	localparam int ADDR_W = 3;
	localparam logic REG_FORMS  = 1'b0;
	localparam logic REG_MAXLEN = 1'b1;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	localparam logic [15:0] LEN_OUT_MAX = 16'hFFFF;

	typedef struct packed {
		logic [7:0] chr;
		logic       last;
		logic [4:0] dval;
	} char_req_t;

	typedef struct packed {
		logic [2:0]  form;
		logic [15:0] len;
		logic        minus;
	} result_req_t;

	function automatic logic [4:0] digit_value(input logic [7:0] c);
		logic [7:0] d;
		d = 8'(DIGIT_NONE);
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = c - CH_ZERO;
		end else if (c >= CH_LA && c <= CH_LF) begin
			d = c - CH_LA + 8'(DIGIT_TEN);
		end else if (c >= CH_UA && c <= CH_UF) begin
			d = c - CH_UA + 8'(DIGIT_TEN);
		end
		return d[4:0];
	endfunction

endpackage

// ===== rtl/pnp_front.sv =====
module pnp_front
	import pnp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] text_char,
	input  logic       last_char,
	output logic       q_valid,
	output char_req_t  q_head,
	input  logic       q_pop
);

	char_req_t         slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;

	assign in_stall = (cnt_q == QCNT_W'(QDEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != '0);
	assign q_head   = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= '{chr: text_char, last: last_char, dval: digit_value(text_char)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (q_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			unique case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/pnp_back.sv =====
module pnp_back
	import pnp_pkg::*;
#(
	parameter int VALUE_BITS  = 64,
	parameter int LENGTH_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [3:0]            accepted_forms,
	input  logic [15:0]           max_length,
	input  logic                  q_valid,
	input  char_req_t             q_head,
	output logic                  q_pop,
	output logic                  res_valid,
	output result_req_t           res,
	output logic [VALUE_BITS-1:0] res_value,
	input  logic                  res_take
);

	localparam int VB = VALUE_BITS;
	localparam int LW = LENGTH_BITS;
	localparam int CW = ((LW > 16) ? LW : 16) + 1;
	localparam logic [LW-1:0] LEN_MAX = '1;

	logic [LW-1:0] pos_q;
	logic [2:0]    phase_q;
	logic          minus_q;
	logic [2:0]    prefix_q;
	logic [1:0]    ov_q;
	logic [VB-1:0] acc_q  [RUNS];
	logic          live_q [RUNS];
	logic [LW-1:0] endp_q [RUNS];

	logic [LW-1:0] pos_n;
	logic [2:0]    phase_n;
	logic          minus_n;
	logic [2:0]    prefix_n;
	logic [1:0]    ov_n;
	logic [VB-1:0] acc_n  [RUNS];
	logic          live_n [RUNS];
	logic [LW-1:0] endp_n [RUNS];

	logic          res_valid_q;
	result_req_t   res_q;
	logic [VB-1:0] res_value_q;

	logic [7:0]    c;
	logic [4:0]    dv;
	logic [CW-1:0] jx;
	logic [CW-1:0] mx;
	logic          m_zero;
	logic          j0, j1, j2;
	logic [LW-1:0] pos_sat;
	logic          pfx_hex, pfx_bin;
	logic          hex_ok, bin_ok;
	logic          dig_ok, skip;
	logic [VB-1:0] mac;

	logic          pok;
	logic [2:0]    form;
	logic [1:0]    sel;
	logic [VB-1:0] val_sel;
	logic [LW-1:0] end_sel;
	logic [CW-1:0] lenx;
	logic [15:0]   len16;
	logic          res_free;

	assign c        = q_head.chr;
	assign dv       = q_head.dval;
	assign res_free = !res_valid_q || res_take;
	assign q_pop    = q_valid && (!q_head.last || res_free);

	always_comb begin
		jx      = CW'(pos_q);
		mx      = CW'(max_length);
		m_zero  = (max_length == '0);
		j0      = (pos_q == LW'(0));
		j1      = (pos_q == LW'(1));
		j2      = (pos_q == LW'(2));
		pos_sat = (pos_q == LEN_MAX) ? pos_q : pos_q + 1'b1;

		pos_n    = pos_q;
		phase_n  = phase_q | 3'b001;
		minus_n  = minus_q;
		prefix_n = prefix_q;
		ov_n     = ov_q;
		hex_ok   = 1'b0;
		bin_ok   = 1'b0;
		pfx_hex  = 1'b0;
		pfx_bin  = 1'b0;
		dig_ok   = 1'b0;
		skip     = 1'b0;
		mac      = '0;
		for (int r = 0; r < RUNS; r++) begin
			acc_n[r]  = acc_q[r];
			live_n[r] = live_q[r];
			endp_n[r] = endp_q[r];
		end

		if (!phase_q[0] && c == CH_MINUS) begin
			minus_n = 1'b1;
		end else begin
			if (j0 && c == CH_ZERO) begin
				phase_n[1] = 1'b1;
			end
			if (j1 && phase_q[1]) begin
				priority if (c == CH_LX) prefix_n = FORM_HEX_LX;
				else if (c == CH_UX) prefix_n = FORM_HEX_UX;
				else if (c == CH_LB) prefix_n = FORM_BIN_LB;
				else if (c == CH_UB) prefix_n = FORM_BIN_UB;
			end
			if (j2 && prefix_q != FORM_DEC && (m_zero || mx > CW'(2))) begin
				hex_ok = (prefix_q <= FORM_HEX_UX) && accepted_forms[AF_HEX] &&
					(dv < DIGIT_NONE);
				bin_ok = (prefix_q >= FORM_BIN_LB) && accepted_forms[AF_BIN] &&
					(dv < 5'd2);
				if (hex_ok || bin_ok) begin
					phase_n[2] = 1'b1;
				end
			end
			if (!j0 && phase_q[1] && !ov_q[1]) begin
				if (dv < DIGIT_TEN) begin
					if (dv > DIGIT_SEVEN) begin
						ov_n = 2'b10;
					end else begin
						ov_n = {(!m_zero && jx == mx), 1'b1};
					end
				end else begin
					ov_n[1] = 1'b1;
				end
			end
			pfx_hex = (prefix_n == FORM_HEX_LX) || (prefix_n == FORM_HEX_UX);
			pfx_bin = (prefix_n == FORM_BIN_LB) || (prefix_n == FORM_BIN_UB);
			for (int r = 0; r < RUNS; r++) begin
				skip = j1 && phase_q[1] &&
					((r == R_HEX && pfx_hex) || (r == R_BIN && pfx_bin));
				unique case (r)
					R_BIN: begin
						dig_ok = dv < 5'd2;
						mac    = (acc_q[r] << 1) + VB'(dv);
					end
					R_OCT: begin
						dig_ok = dv < 5'd8;
						mac    = (acc_q[r] << 3) + VB'(dv);
					end
					R_DEC: begin
						dig_ok = dv < DIGIT_TEN;
						mac    = (acc_q[r] << 3) + (acc_q[r] << 1) + VB'(dv);
					end
					default: begin
						dig_ok = dv < DIGIT_NONE;
						mac    = (acc_q[r] << 4) + VB'(dv);
					end
				endcase
				if (live_q[r] && !skip) begin
					if (dig_ok) begin
						acc_n[r]  = mac;
						endp_n[r] = pos_sat;
						if (!m_zero && (jx + 1'b1) == mx) begin
							live_n[r] = 1'b0;
						end
					end else begin
						live_n[r] = 1'b0;
					end
				end
			end
			pos_n = pos_sat;
		end
	end

	always_comb begin
		pok = phase_n[2];
		priority if (pok) begin
			form = prefix_n;
		end else if (accepted_forms[AF_OCT] && phase_n[1] && ov_n[0] &&
			(m_zero || mx > CW'(1))) begin
			form = FORM_OCT;
		end else begin
			form = FORM_DEC;
		end

		priority if (form == FORM_BIN_LB || form == FORM_BIN_UB ||
			accepted_forms == AF_ONLY_BIN) begin
			sel = 2'(R_BIN);
		end else if (form == FORM_OCT || accepted_forms == AF_ONLY_OCT) begin
			sel = 2'(R_OCT);
		end else if (form == FORM_HEX_LX || form == FORM_HEX_UX ||
			accepted_forms == AF_ONLY_HEX) begin
			sel = 2'(R_HEX);
		end else begin
			sel = 2'(R_DEC);
		end

		val_sel = acc_n[sel];
		end_sel = endp_n[sel];
		if (!pok && ((sel == 2'(R_BIN) && (prefix_n == FORM_BIN_LB ||
			prefix_n == FORM_BIN_UB)) || (sel == 2'(R_HEX) &&
			(prefix_n == FORM_HEX_LX || prefix_n == FORM_HEX_UX)))) begin
			val_sel = '0;
			end_sel = LW'(1);
		end

		lenx = CW'(end_sel) + CW'(minus_n);
		if (lenx > CW'(LEN_MAX)) begin
			lenx = CW'(LEN_MAX);
		end
		len16 = (lenx > CW'(LEN_OUT_MAX)) ? LEN_OUT_MAX : lenx[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			phase_q     <= '0;
			minus_q     <= 1'b0;
			prefix_q    <= FORM_DEC;
			ov_q        <= '0;
			res_valid_q <= 1'b0;
			for (int r = 0; r < RUNS; r++) begin
				acc_q[r]  <= '0;
				live_q[r] <= 1'b1;
				endp_q[r] <= '0;
			end
		end else begin
			if (q_pop && q_head.last) begin
				pos_q       <= '0;
				phase_q     <= '0;
				minus_q     <= 1'b0;
				prefix_q    <= FORM_DEC;
				ov_q        <= '0;
				res_valid_q <= 1'b1;
				for (int r = 0; r < RUNS; r++) begin
					acc_q[r]  <= '0;
					live_q[r] <= 1'b1;
					endp_q[r] <= '0;
				end
			end else begin
				if (q_pop) begin
					pos_q    <= pos_n;
					phase_q  <= phase_n;
					minus_q  <= minus_n;
					prefix_q <= prefix_n;
					ov_q     <= ov_n;
					for (int r = 0; r < RUNS; r++) begin
						acc_q[r]  <= acc_n[r];
						live_q[r] <= live_n[r];
						endp_q[r] <= endp_n[r];
					end
				end
				if (res_take) begin
					res_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_head.last) begin
			res_q       <= '{form: form, len: len16, minus: minus_n};
			res_value_q <= val_sel;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign res_value = res_value_q;

endmodule

// ===== rtl/pnp_finish.sv =====
module pnp_finish
	import pnp_pkg::*;
#(
	parameter int VALUE_BITS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  res_valid,
	input  result_req_t           res,
	input  logic [VALUE_BITS-1:0] res_value,
	output logic                  res_take,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [2:0]            number_form,
	output logic [15:0]           consumed_length,
	output logic signed [63:0]    signed_value,
	output logic [63:0]           unsigned_value
);

	logic                  out_valid_q;
	logic [2:0]            form_q;
	logic [15:0]           len_q;
	logic signed [63:0]    sval_q;
	logic [63:0]           uval_q;
	logic [VALUE_BITS-1:0] sv;
	logic                  load;

	assign res_take = !out_valid_q || !out_stall;
	assign load     = res_valid && res_take;
	assign sv       = res.minus ? (VALUE_BITS'(0) - res_value) : res_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			form_q <= res.form;
			len_q  <= res.len;
			sval_q <= 64'($signed(sv));
			uval_q <= 64'(res_value);
		end
	end

	assign out_valid       = out_valid_q;
	assign number_form     = form_q;
	assign consumed_length = len_q;
	assign signed_value    = sval_q;
	assign unsigned_value  = uval_q;

endmodule

// ===== rtl/prefixed_number_text_parser.sv =====
// Number text parser: feed one byte of a number string per request, with last_char set on the
// final byte, and one result (form, characters consumed, signed and unsigned value) follows
// for each string. Bytes are taken at one per cycle while in_stall is low, with no gaps between
// strings; a four-entry queue separates the byte classifier from the parse state update. While
// a result waits on out_stall, one more string can finish into the back end's result register;
// bytes are then taken until the next string's last byte reaches the head of the queue and the
// queue fills behind it. The parse state update handles one byte per cycle unless a last byte
// waits for the result register; a result passes the parse update register, then the negate
// and output register. Registers accepted_forms (address 0) and max_length (address 4) must
// be written by the user only while no string is in flight; the block does not enforce it.
module prefixed_number_text_parser
	import pnp_pkg::*;
#(
	parameter int VALUE_BITS  = 64,
	parameter int LENGTH_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         text_char,
	input  logic               last_char,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         number_form,
	output logic [15:0]        consumed_length,
	output logic signed [63:0] signed_value,
	output logic [63:0]        unsigned_value,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [3:0]            forms_q;
	logic [15:0]           maxlen_q;
	logic                  q_valid;
	char_req_t             q_head;
	logic                  q_pop;
	logic                  res_valid;
	result_req_t           res;
	logic [VALUE_BITS-1:0] res_value;
	logic                  res_take;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			forms_q  <= '0;
			maxlen_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[ADDR_W-1])
				REG_FORMS:  forms_q  <= pwdata[3:0];
				REG_MAXLEN: maxlen_q <= pwdata[15:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[ADDR_W-1])
			REG_FORMS:  prdata = 32'(forms_q);
			REG_MAXLEN: prdata = 32'(maxlen_q);
		endcase
	end

	pnp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.text_char (text_char),
		.last_char (last_char),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop)
	);

	pnp_back #(
		.VALUE_BITS  (VALUE_BITS),
		.LENGTH_BITS (LENGTH_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.accepted_forms (forms_q),
		.max_length     (maxlen_q),
		.q_valid        (q_valid),
		.q_head         (q_head),
		.q_pop          (q_pop),
		.res_valid      (res_valid),
		.res            (res),
		.res_value      (res_value),
		.res_take       (res_take)
	);

	pnp_finish #(
		.VALUE_BITS (VALUE_BITS)
	) u_finish (
		.clk             (clk),
		.arst_n          (arst_n),
		.res_valid       (res_valid),
		.res             (res),
		.res_value       (res_value),
		.res_take        (res_take),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.number_form     (number_form),
		.consumed_length (consumed_length),
		.signed_value    (signed_value),
		.unsigned_value  (unsigned_value)
	);

endmodule

// ===== rtl/pnp_checker.sv =====
module pnp_checker
	import pnp_pkg::*;
#(
	parameter int VALUE_BITS = 64
) (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic [2:0]         number_form,
	input logic [15:0]        consumed_length,
	input logic signed [63:0] signed_value,
	input logic [63:0]        unsigned_value
);

	localparam logic [63:0] VMASK = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - VALUE_BITS);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(unsigned_value) &&
		$stable(signed_value) && $stable(consumed_length) && $stable(number_form))
		else $error("stalled result changed");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && consumed_length == 16'd0 |-> unsigned_value == 64'd0 &&
		signed_value == 64'sd0)
		else $error("nonzero value with no characters consumed");

	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((64'(signed_value) & VMASK) == (unsigned_value & VMASK)) ||
		((64'(signed_value) & VMASK) == ((64'd0 - unsigned_value) & VMASK)))
		else $error("signed value is neither the value nor its negation");

	a_prefix_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (number_form == FORM_HEX_LX || number_form == FORM_HEX_UX ||
		number_form == FORM_BIN_LB || number_form == FORM_BIN_UB) |->
		consumed_length >= 16'd3)
		else $error("prefixed form with too few characters");

endmodule

bind prefixed_number_text_parser pnp_checker #(
	.VALUE_BITS (VALUE_BITS)
) u_pnp_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.number_form     (number_form),
	.consumed_length (consumed_length),
	.signed_value    (signed_value),
	.unsigned_value  (unsigned_value)
);

// ===== tb/prefixed_number_text_parser_tb.sv =====
module prefixed_number_text_parser_tb;
	import pnp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STUCK_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASES = 13;
	localparam logic [ADDR_W-1:0] ADDR_FORMS = ADDR_W'({REG_FORMS, 2'b00});
	localparam logic [ADDR_W-1:0] ADDR_MAXLEN = ADDR_W'({REG_MAXLEN, 2'b00});

	typedef struct {
		logic [7:0] chr;
		logic       fin;
		logic       drain;
	} text_req_t;

	typedef struct packed {
		logic [2:0]  form;
		logic [15:0] len;
		logic [63:0] sval;
		logic [63:0] uval;
	} number_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] text_char = 8'h00;
	logic last_char = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] number_form;
	logic [15:0] consumed_length;
	logic signed [63:0] signed_value;
	logic [63:0] unsigned_value;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	text_req_t text_reqs[$];
	number_t expected_numbers[$];
	int errors = 0;
	int pushed = 0;
	int stuck = 0;
	logic in_taken = 1'b0;
	logic steady = 1'b0;

	logic [3:0] cfg_forms = '0;
	logic [15:0] cfg_maxlen = '0;

	logic sign_done, lead_zero, prefix_ok, minus, oct_digit, oct_done;
	logic [2:0] prefix;
	int unsigned body_pos;
	logic [63:0] run_acc[RUNS];
	logic run_live[RUNS];
	int unsigned run_end[RUNS];

	prefixed_number_text_parser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.text_char(text_char),
		.last_char(last_char),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.number_form(number_form),
		.consumed_length(consumed_length),
		.signed_value(signed_value),
		.unsigned_value(unsigned_value),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	function automatic logic [4:0] char_digit(input logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE) return 5'(c - CH_ZERO);
		if (c >= CH_LA && c <= CH_LF) return 5'(c - CH_LA) + DIGIT_TEN;
		if (c >= CH_UA && c <= CH_UF) return 5'(c - CH_UA) + DIGIT_TEN;
		return DIGIT_NONE;
	endfunction

	function automatic logic [4:0] radix_base(input int r);
		case (r)
			R_BIN: return 5'd2;
			R_OCT: return 5'd8;
			R_DEC: return 5'd10;
			default: return 5'd16;
		endcase
	endfunction

	function automatic logic is_hex(input logic [2:0] f);
		return f == FORM_HEX_LX || f == FORM_HEX_UX;
	endfunction

	function automatic logic is_bin(input logic [2:0] f);
		return f == FORM_BIN_LB || f == FORM_BIN_UB;
	endfunction

	function automatic int unsigned bump(input int unsigned v);
		return v >= LEN_OUT_MAX ? LEN_OUT_MAX : v + 1;
	endfunction

	function automatic void clear_number();
		sign_done = 1'b0;
		lead_zero = 1'b0;
		prefix_ok = 1'b0;
		minus = 1'b0;
		oct_digit = 1'b0;
		oct_done = 1'b0;
		prefix = FORM_DEC;
		body_pos = 0;
		for (int r = 0; r < RUNS; r++) begin
			run_acc[r] = '0;
			run_live[r] = 1'b1;
			run_end[r] = 0;
		end
	endfunction

	function automatic void body_byte(input logic [7:0] c);
		int unsigned j, m;
		logic [4:0] d, base;
		j = body_pos;
		m = cfg_maxlen;
		d = char_digit(c);
		if (j == 0 && c == CH_ZERO) lead_zero = 1'b1;
		if (j == 1 && lead_zero) begin
			if (c == CH_LX) prefix = FORM_HEX_LX;
			else if (c == CH_UX) prefix = FORM_HEX_UX;
			else if (c == CH_LB) prefix = FORM_BIN_LB;
			else if (c == CH_UB) prefix = FORM_BIN_UB;
		end
		if (j == 2 && prefix != FORM_DEC && (m == 0 || m > 2)) begin
			if ((is_hex(prefix) && cfg_forms[AF_HEX] && d < DIGIT_NONE) ||
					(is_bin(prefix) && cfg_forms[AF_BIN] && d < 5'd2))
				prefix_ok = 1'b1;
		end
		if (j >= 1 && lead_zero && !oct_done) begin
			if (c >= CH_ZERO && c <= CH_NINE) begin
				if (d > DIGIT_SEVEN) begin
					oct_digit = 1'b0;
					oct_done = 1'b1;
				end else begin
					oct_digit = 1'b1;
					if (m != 0 && j == m) oct_done = 1'b1;
				end
			end else begin
				oct_done = 1'b1;
			end
		end
		for (int r = 0; r < RUNS; r++) begin
			if (run_live[r] && !(j == 1 && lead_zero &&
					((r == R_HEX && is_hex(prefix)) || (r == R_BIN && is_bin(prefix))))) begin
				base = radix_base(r);
				if (d < base) begin
					run_acc[r] = run_acc[r] * 64'(base) + 64'(d);
					run_end[r] = bump(j);
					if (m != 0 && j + 1 == m) run_live[r] = 1'b0;
				end else begin
					run_live[r] = 1'b0;
				end
			end
		end
		body_pos = bump(j);
	endfunction

	function automatic void close_number();
		number_t n;
		logic [2:0] form;
		int sel;
		logic [63:0] val;
		int unsigned e, len;
		if (prefix_ok) form = prefix;
		else if (cfg_forms[AF_OCT] && lead_zero && oct_digit && (cfg_maxlen == 0 || cfg_maxlen > 1))
			form = FORM_OCT;
		else form = FORM_DEC;
		if (is_bin(form) || cfg_forms == AF_ONLY_BIN) sel = R_BIN;
		else if (form == FORM_OCT || cfg_forms == AF_ONLY_OCT) sel = R_OCT;
		else if (is_hex(form) || cfg_forms == AF_ONLY_HEX) sel = R_HEX;
		else sel = R_DEC;
		val = run_acc[sel];
		e = run_end[sel];
		if (!prefix_ok && ((sel == R_BIN && is_bin(prefix)) || (sel == R_HEX && is_hex(prefix)))) begin
			val = '0;
			e = 1;
		end
		len = e + (minus ? 1 : 0);
		if (len > LEN_OUT_MAX) len = LEN_OUT_MAX;
		n.form = form;
		n.len = 16'(len);
		n.sval = minus ? 64'd0 - val : val;
		n.uval = val;
		expected_numbers.push_back(n);
		clear_number();
	endfunction

	function automatic void parse_byte(input logic [7:0] c, input logic fin);
		if (!sign_done) begin
			sign_done = 1'b1;
			if (c == CH_MINUS) minus = 1'b1;
			else body_byte(c);
		end else begin
			body_byte(c);
		end
		if (fin) close_number();
	endfunction

	task automatic push_char(input logic [7:0] c, input logic fin, input logic drain);
		text_reqs.push_back('{chr: c, fin: fin, drain: drain});
		pushed++;
	endtask

	task automatic push_word(input string s);
		for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1, 1'b0);
	endtask

	function automatic logic [7:0] pick_digit(input int radix);
		int v;
		v = $urandom_range(radix - 1);
		if (v < 10) return CH_ZERO + 8'(v);
		return ($urandom_range(1) ? CH_LA : CH_UA) + 8'(v - 10);
	endfunction

	task automatic push_random_number(input logic drain);
		logic [7:0] s[$];
		int n, radix;
		if ($urandom_range(99) < 8) begin
			n = $urandom_range(1, 6);
			repeat (n) s.push_back(8'($urandom));
		end else begin
			if ($urandom_range(3) == 0) s.push_back(CH_MINUS);
			case ($urandom_range(5))
				0: begin
					s.push_back(CH_ZERO);
					s.push_back($urandom_range(1) ? CH_LX : CH_UX);
					radix = 16;
				end
				1: begin
					s.push_back(CH_ZERO);
					s.push_back($urandom_range(1) ? CH_LB : CH_UB);
					radix = 2;
				end
				2: begin
					s.push_back(CH_ZERO);
					radix = 8;
				end
				3: radix = 10;
				4: radix = 16;
				default: radix = 2;
			endcase
			n = $urandom_range(7) == 0 ? $urandom_range(70) : $urandom_range(12);
			repeat (n) s.push_back(pick_digit(radix));
			if (s.size() == 0) s.push_back(pick_digit(10));
			if ($urandom_range(9) == 0) s[$urandom_range(s.size() - 1)] = 8'($urandom);
		end
		for (int k = 0; k < s.size(); k++) push_char(s[k], k == s.size() - 1, drain && k == 0);
	endtask

	task automatic write_reg(input logic [ADDR_W-1:0] a, input logic [31:0] v);
		logic [31:0] mask, rd;
		mask = a == ADDR_FORMS ? 32'hF : 32'hFFFF;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (a == ADDR_FORMS) cfg_forms = v[3:0];
		else cfg_maxlen = v[15:0];
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		if ((rd & mask) !== (v & mask)) report_mismatch("register readback", 64'(rd & mask),
				64'(v & mask));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_config(input logic [3:0] forms, input logic [15:0] maxlen);
		logic [31:0] v;
		v = $urandom();
		v[3:0] = forms;
		write_reg(ADDR_FORMS, v);
		v = $urandom();
		v[15:0] = maxlen;
		write_reg(ADDR_MAXLEN, v);
	endtask

	task automatic settle();
		while (text_reqs.size() != 0 || in_valid || expected_numbers.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(negedge clk) begin : drive
		text_req_t req;
		logic go;
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				go = text_reqs.size() != 0 && (steady || $urandom_range(99) >= 28);
				if (go && text_reqs[0].drain && expected_numbers.size() != 0) go = 1'b0;
				if (go) begin
					req = text_reqs.pop_front();
					in_valid <= 1'b1;
					text_char <= req.chr;
					last_char <= req.fin;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= !steady && $urandom_range(99) < 28;
		end
	end

	always @(posedge clk) begin : watch
		number_t want;
		logic busy;
		busy = 1'b0;
		in_taken = 1'b0;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				parse_byte(text_char, last_char);
				in_taken = 1'b1;
				busy = 1'b1;
			end
			if (out_valid && !out_stall) begin
				busy = 1'b1;
				if (expected_numbers.size() == 0) begin
					report_mismatch("result with no number pending", 64'(unsigned_value), '0);
				end else begin
					want = expected_numbers.pop_front();
					if (number_form !== want.form)
						report_mismatch("number_form", 64'(number_form), 64'(want.form));
					if (consumed_length !== want.len)
						report_mismatch("consumed_length", 64'(consumed_length), 64'(want.len));
					if (signed_value !== want.sval)
						report_mismatch("signed_value", signed_value, want.sval);
					if (unsigned_value !== want.uval)
						report_mismatch("unsigned_value", unsigned_value, want.uval);
				end
			end
			stuck = busy ? 0 : stuck + 1;
			if (stuck >= STUCK_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int start, quota;
		logic pause_done;
		logic [3:0] forms;
		logic [15:0] maxlen;
		clear_number();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		set_config(4'b0111, 16'd0);
		push_word("-0x1F");
		push_word("0B10");
		push_word("017");
		push_word("09");
		push_word("-");
		push_char(8'h00, 1'b1, 1'b0);
		push_char(8'hFF, 1'b1, 1'b0);
		push_word("0X");
		settle();
		set_config(AF_ONLY_HEX, 16'd0);
		push_word("0xz");
		settle();
		set_config(AF_ONLY_BIN, 16'hFFFF);
		push_word("0b2");
		settle();

		pause_done = 1'b0;
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin forms = 4'd7; maxlen = 16'd0; end
				1: begin forms = 4'd15; maxlen = 16'd0; end
				2: begin forms = AF_ONLY_HEX; maxlen = 16'd3; end
				3: begin forms = AF_ONLY_OCT; maxlen = 16'd1; end
				4: begin forms = AF_ONLY_BIN; maxlen = 16'd2; end
				5: begin forms = 4'd0; maxlen = 16'hFFFF; end
				6: begin forms = 4'd2; maxlen = 16'($urandom_range(4, 24)); end
				7: begin forms = 4'd5; maxlen = 16'd0; end
				8: begin forms = 4'd3; maxlen = 16'($urandom_range(1, 12)); end
				9: begin forms = 4'd6; maxlen = 16'($urandom_range(65535)); end
				default: begin
					forms = 4'($urandom_range(15));
					maxlen = $urandom_range(1) ? 16'($urandom_range(30)) : 16'($urandom_range(65535));
				end
			endcase
			set_config(forms, maxlen);
			steady = p == 4;
			quota = p == 4 ? 120 : 65;
			start = pushed;
			while (pushed - start < quota) begin
				if (p == 2 && !pause_done && pushed - start >= 40) begin
					push_random_number(1'b1);
					pause_done = 1'b1;
				end else begin
					push_random_number(1'b0);
				end
			end
			settle();
		end
		steady = 1'b0;

		set_config(4'd0, 16'd0);
		push_char(CH_MINUS, 1'b0, 1'b0);
		repeat (40) push_char(pick_digit(10), 1'b0, 1'b0);
		push_char(CH_ZERO + 8'd7, 1'b1, 1'b0);
		settle();

		if (expected_numbers.size() != 0)
			report_mismatch("numbers never returned", 64'(expected_numbers.size()), '0);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
